[hw/rtl/lsg_pkg.sv]
package lsg_pkg;

   localparam int SAMPLE_W         = 25;
   localparam int SUM_W            = 30;
   localparam int LEVEL_W          = 25;
   localparam int X100_W           = 24;
   localparam int COUNT_W          = 4;
   localparam int MIN_CHANGE_W     = 8;
   localparam int CSR_DATA_W       = 8;
   localparam int PROD_W           = 32;
   localparam int X100_SCALE       = 100;
   localparam int COUNT_RESET      = 1;
   localparam int MIN_CHANGE_RESET = 32;

   typedef enum logic [0:0] {
      REG_SAMPLE_COUNT = 1'b0,
      REG_MIN_CHANGE   = 1'b1
   } csr_index_type;

endpackage

[hw/rtl/lsg_divider.sv]
// restoring divider, one quotient bit per cycle
module lsg_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lsg_pkg::SUM_W-1:0]    dividend,
   input  logic [lsg_pkg::COUNT_W-1:0]  divisor,
   output logic                         done,
   output logic [lsg_pkg::SUM_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(lsg_pkg::SUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lsg_pkg::SUM_W - 1);

   logic                         busy_ff,  busy_in;
   logic                         done_ff,  done_in;
   logic [CNT_W-1:0]             cnt_ff,   cnt_in;
   logic [lsg_pkg::SUM_W-1:0]    quo_ff,   quo_in;
   logic [lsg_pkg::COUNT_W-1:0]  rem_ff,   rem_in;
   logic [lsg_pkg::COUNT_W-1:0]  div_ff,   div_in;
   logic [lsg_pkg::COUNT_W:0]    trial;
   logic                         fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[lsg_pkg::SUM_W-1]};
      fits    = trial >= {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? lsg_pkg::COUNT_W'(trial - {1'b0, div_ff})
                       : lsg_pkg::COUNT_W'(trial);
         quo_in = {quo_ff[lsg_pkg::SUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/lux_smoother_with_change_gate.sv]
// Ambient light smoother with a change gate.
// Request channel (req_valid / req_stall): one light sample in lux, unsigned
// fixed point with FRAC_BITS fraction bits, plus a hold flag. Each transaction
// yields exactly one response transaction (rsp_valid / rsp_stall) carrying the
// reported flag, the last reported lux x100 value and the smoothing mode.
// With sample_count above one the running sum is divided by sample_count in a
// 30-step restoring divider. In pass-through mode (sample_count of one) the
// sample skips the divider. One item is in flight at a time; req_stall is high
// while it is worked on.
// The response sits in an output register. When the receiver stalls, the
// finished response holds there and the block stops in its last step until
// the register is free.
// csr_write_enable writes register csr_index: sample_count
// (clamped to 1..MAX_SAMPLES, clears all smoothing state) or min_change.
// Writes must be made by the user only while no transaction is outstanding;
// the block does not enforce this. Synchronous reset: sample_count 1,
// min_change 32, state cleared, no response pending.
module lux_smoother_with_change_gate #(
   parameter int FRAC_BITS   = 8,
   parameter int MAX_SAMPLES = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lsg_pkg::SAMPLE_W-1:0]      req_sample_lux_q8,
   input  logic                              req_hold_updates,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_reported,
   output logic [lsg_pkg::X100_W-1:0]        rsp_lux_x100,
   output logic                              rsp_smoothing_on,
   input  logic                              csr_write_enable,
   input  logic [0:0]                        csr_index,
   input  logic [lsg_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACCUM,
      S_DIV,
      S_SCALE,
      S_GATE
   } state_type;

   localparam logic [lsg_pkg::SUM_W:0]    SUM_MAX   = {1'b0, {lsg_pkg::SUM_W{1'b1}}};
   localparam logic [lsg_pkg::LEVEL_W-1:0] LEVEL_MAX = '1;
   localparam logic [lsg_pkg::PROD_W:0]   HALF      = (lsg_pkg::PROD_W+1)'(1) << (FRAC_BITS - 1);
   localparam logic [lsg_pkg::PROD_W:0]   X100_MAX  = (lsg_pkg::PROD_W+1)'({lsg_pkg::X100_W{1'b1}});

   state_type                          state_ff,      state_in;
   logic [lsg_pkg::COUNT_W-1:0]        count_ff,      count_in;
   logic [lsg_pkg::MIN_CHANGE_W-1:0]   min_change_ff, min_change_in;
   logic [lsg_pkg::SUM_W-1:0]          sum_ff,        sum_in;
   logic [lsg_pkg::LEVEL_W-1:0]        level_ff,      level_in;
   logic [lsg_pkg::X100_W-1:0]         last_ff,       last_in;
   logic [lsg_pkg::SAMPLE_W-1:0]       sample_ff,     sample_in;
   logic                               hold_ff,       hold_in;
   logic [lsg_pkg::PROD_W-1:0]         prod_ff,       prod_in;
   logic                               div_start_ff,  div_start_in;
   logic                               rsp_valid_ff,  rsp_valid_in;
   logic                               rsp_rep_ff,    rsp_rep_in;
   logic [lsg_pkg::X100_W-1:0]         rsp_lux_ff,    rsp_lux_in;
   logic                               rsp_smooth_ff, rsp_smooth_in;

   logic                               smoothing;
   logic                               out_free;
   logic                               div_done;
   logic [lsg_pkg::SUM_W-1:0]          div_quotient;
   logic [lsg_pkg::SUM_W:0]            acc;
   logic [lsg_pkg::PROD_W:0]           rounded;
   logic [lsg_pkg::X100_W-1:0]         fresh;
   logic [lsg_pkg::X100_W-1:0]         change;
   logic                               update;
   logic [lsg_pkg::COUNT_W-1:0]        new_count;

   lsg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign smoothing = count_ff > lsg_pkg::COUNT_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      min_change_in = min_change_ff;
      sum_in        = sum_ff;
      level_in      = level_ff;
      last_in       = last_ff;
      sample_in     = sample_ff;
      hold_in       = hold_ff;
      prod_in       = prod_ff;
      div_start_in  = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_rep_in    = rsp_rep_ff;
      rsp_lux_in    = rsp_lux_ff;
      rsp_smooth_in = rsp_smooth_ff;

      acc = {1'b0, sum_ff} + (lsg_pkg::SUM_W+1)'(sample_ff);
      if (acc >= (lsg_pkg::SUM_W+1)'(level_ff)) begin
         acc = acc - (lsg_pkg::SUM_W+1)'(level_ff);
      end else begin
         acc = '0;
      end
      if (acc > SUM_MAX) begin
         acc = SUM_MAX;
      end

      rounded = ((lsg_pkg::PROD_W+1)'(prod_ff) + HALF) >> FRAC_BITS;
      fresh   = (rounded > X100_MAX) ? '1 : lsg_pkg::X100_W'(rounded);
      change  = (fresh >= last_ff) ? fresh - last_ff : last_ff - fresh;
      update  = !hold_ff && (change != '0)
                && ((change >= lsg_pkg::X100_W'(min_change_ff))
                    || (fresh < lsg_pkg::X100_W'(min_change_ff)));

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample_lux_q8;
               hold_in   = req_hold_updates;
               state_in  = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (smoothing) begin
               sum_in       = lsg_pkg::SUM_W'(acc);
               div_start_in = 1'b1;
               state_in     = S_DIV;
            end else begin
               level_in = sample_ff;
               state_in = S_SCALE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               level_in = (div_quotient[lsg_pkg::SUM_W-1:lsg_pkg::LEVEL_W] != '0)
                          ? LEVEL_MAX : div_quotient[lsg_pkg::LEVEL_W-1:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            prod_in  = lsg_pkg::PROD_W'(level_ff) * lsg_pkg::PROD_W'(lsg_pkg::X100_SCALE);
            state_in = S_GATE;
         end
         S_GATE: begin
            if (out_free) begin
               if (update) begin
                  last_in = fresh;
               end
               rsp_valid_in  = 1'b1;
               rsp_rep_in    = update;
               rsp_lux_in    = update ? fresh : last_ff;
               rsp_smooth_in = smoothing;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      new_count = csr_write_data[lsg_pkg::COUNT_W-1:0];
      if (new_count == '0) begin
         new_count = lsg_pkg::COUNT_W'(1);
      end else if (32'(new_count) > MAX_SAMPLES) begin
         new_count = lsg_pkg::COUNT_W'(MAX_SAMPLES);
      end

      if (csr_write_enable) begin
         unique case (lsg_pkg::csr_index_type'(csr_index))
            lsg_pkg::REG_SAMPLE_COUNT: begin
               count_in = new_count;
               sum_in   = '0;
               level_in = '0;
               last_in  = '0;
            end
            lsg_pkg::REG_MIN_CHANGE: begin
               min_change_in = csr_write_data[lsg_pkg::MIN_CHANGE_W-1:0];
            end
            default: begin
               min_change_in = min_change_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      hold_ff       <= hold_in;
      prod_ff       <= prod_in;
      rsp_rep_ff    <= rsp_rep_in;
      rsp_lux_ff    <= rsp_lux_in;
      rsp_smooth_ff <= rsp_smooth_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= lsg_pkg::COUNT_W'(lsg_pkg::COUNT_RESET);
         min_change_ff <= lsg_pkg::MIN_CHANGE_W'(lsg_pkg::MIN_CHANGE_RESET);
         sum_ff        <= '0;
         level_ff      <= '0;
         last_ff       <= '0;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         min_change_ff <= min_change_in;
         sum_ff        <= sum_in;
         level_ff      <= level_in;
         last_ff       <= last_in;
         div_start_ff  <= div_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_stall        = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reported     = rsp_rep_ff;
   assign rsp_lux_x100     = rsp_lux_ff;
   assign rsp_smoothing_on = rsp_smooth_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide step");

   a_pass_through_skips_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACCUM) && !smoothing |=> state_ff == S_SCALE)
      else $error("pass-through item entered the divider");

   a_report_changes_value: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == S_GATE && out_free) && rsp_reported
         |-> rsp_lux_x100 != $past(last_ff))
      else $error("reported value equals previous report");
`endif

endmodule

[dv/lux_gate_checker.sv]
`timescale 1ns / 100ps

module lux_gate_checker
   import lsg_pkg::*;
#(
   parameter int FRAC_BITS   = 8,
   parameter int MAX_SAMPLES = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [SAMPLE_W-1:0]     req_sample_lux_q8,
   input  logic                    req_hold_updates,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_reported,
   input  logic [X100_W-1:0]       rsp_lux_x100,
   input  logic                    rsp_smoothing_on,
   input  logic                    csr_write_enable,
   input  logic [0:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   output int                      mismatches,
   output int                      outstanding,
   output int                      checked,
   output int                      updates
);

   localparam logic [31:0] SUM_LIMIT   = (32'd1 << SUM_W) - 32'd1;
   localparam logic [31:0] LEVEL_LIMIT = (32'd1 << LEVEL_W) - 32'd1;
   localparam logic [39:0] X100_LIMIT  = (40'd1 << X100_W) - 40'd1;
   localparam logic [39:0] ROUND_HALF  = 40'd1 << (FRAC_BITS - 1);

   typedef struct packed {
      logic              reported;
      logic [X100_W-1:0] lux_x100;
      logic              smoothing_on;
   } lux_reading_t;

   lux_reading_t            reading_queue[$];
   logic [COUNT_W-1:0]      depth_q;
   logic [MIN_CHANGE_W-1:0] gate_q;
   logic [SUM_W-1:0]        sum_q;
   logic [LEVEL_W-1:0]      level_q;
   logic [X100_W-1:0]       shown_q;
   int                      fail_total = 0;
   int                      checked_total = 0;
   int                      update_total = 0;

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("mismatch: %s at response %0d, got %0d, expected %0d",
               what, checked_total, seen, wanted);
      fail_total++;
   endtask

   task automatic predict_reading(input logic [SAMPLE_W-1:0] lux, input logic hold,
                                  output lux_reading_t r);
      logic [31:0]       acc;
      logic [39:0]       scaled;
      logic [X100_W-1:0] fresh;
      logic [X100_W-1:0] delta;
      logic              smoothing;
      smoothing  = depth_q > 1;
      r.reported = 1'b0;
      if (smoothing) begin
         acc = 32'(sum_q) + 32'(lux);
         acc = (acc >= 32'(level_q)) ? acc - 32'(level_q) : 32'd0;
         if (acc > SUM_LIMIT) acc = SUM_LIMIT;
         sum_q = acc[SUM_W-1:0];
         acc = acc / 32'(depth_q);
         level_q = (acc > LEVEL_LIMIT) ? '1 : acc[LEVEL_W-1:0];
      end else begin
         level_q = lux;
      end
      scaled = (40'(level_q) * 40'(X100_SCALE) + ROUND_HALF) >> FRAC_BITS;
      fresh = (scaled > X100_LIMIT) ? '1 : scaled[X100_W-1:0];
      if (!hold) begin
         delta = (fresh >= shown_q) ? fresh - shown_q : shown_q - fresh;
         if (delta != 0 && (delta >= X100_W'(gate_q) || fresh < X100_W'(gate_q))) begin
            shown_q    = fresh;
            r.reported = 1'b1;
         end
      end
      r.lux_x100     = shown_q;
      r.smoothing_on = smoothing;
   endtask

   always @(posedge clock) begin
      lux_reading_t       want;
      logic [COUNT_W-1:0] n;
      if (reset) begin
         depth_q = COUNT_W'(COUNT_RESET);
         gate_q  = MIN_CHANGE_W'(MIN_CHANGE_RESET);
         sum_q   = '0;
         level_q = '0;
         shown_q = '0;
         reading_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               REG_SAMPLE_COUNT: begin
                  n = csr_write_data[COUNT_W-1:0];
                  if (n < 1) n = COUNT_W'(1);
                  else if (n > MAX_SAMPLES) n = COUNT_W'(MAX_SAMPLES);
                  depth_q = n;
                  sum_q   = '0;
                  level_q = '0;
                  shown_q = '0;
               end
               REG_MIN_CHANGE: gate_q = csr_write_data[MIN_CHANGE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (reading_queue.size() == 0) begin
               report_mismatch("response with none expected", 32'(rsp_lux_x100), 32'd0);
            end else begin
               want = reading_queue.pop_front();
               if (rsp_reported !== want.reported)
                  report_mismatch("reported", 32'(rsp_reported), 32'(want.reported));
               if (rsp_lux_x100 !== want.lux_x100)
                  report_mismatch("lux_x100", 32'(rsp_lux_x100), 32'(want.lux_x100));
               if (rsp_smoothing_on !== want.smoothing_on)
                  report_mismatch("smoothing_on", 32'(rsp_smoothing_on),
                                  32'(want.smoothing_on));
               if (want.reported) update_total++;
            end
            checked_total++;
         end
         if (req_valid && !req_stall) begin
            predict_reading(req_sample_lux_q8, req_hold_updates, want);
            reading_queue.push_back(want);
         end
      end
      mismatches  <= fail_total;
      outstanding <= reading_queue.size();
      checked     <= checked_total;
      updates     <= update_total;
   end

endmodule

[dv/tb_lux_smoother_with_change_gate.sv]
`timescale 1ns / 100ps

module tb_lux_smoother_with_change_gate;
   import lsg_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam logic [24:0] LUX_MAX     = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample_lux_q8 = '0;
   logic                  req_hold_updates = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_reported;
   logic [X100_W-1:0]     rsp_lux_x100;
   logic                  rsp_smoothing_on;
   logic                  csr_write_enable = 1'b0;
   logic [0:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int  mismatches;
   int  outstanding;
   int  checked;
   int  updates;
   int  cycle_count = 0;
   int  settings = 0;
   int  long_hold_cycles = 0;
   bit  no_gaps = 1'b0;

   always #5 clock = ~clock;

   lux_smoother_with_change_gate i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_lux_q8 (req_sample_lux_q8),
      .req_hold_updates  (req_hold_updates),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reported      (rsp_reported),
      .rsp_lux_x100      (rsp_lux_x100),
      .rsp_smoothing_on  (rsp_smoothing_on),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   lux_gate_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_lux_q8 (req_sample_lux_q8),
      .req_hold_updates  (req_hold_updates),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reported      (rsp_reported),
      .rsp_lux_x100      (rsp_lux_x100),
      .rsp_smoothing_on  (rsp_smoothing_on),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .checked           (checked),
      .updates           (updates)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transactions pending",
                  cycle_count, outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response side: random stall per transaction, plus one long hold-off on request
   initial begin
      int gap;
      int hold_len;
      bit long_hold_taken;
      long_hold_taken = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         hold_len = (long_hold_cycles > 0 && !long_hold_taken) ? long_hold_cycles : 0;
         if (hold_len > 0) long_hold_taken = 1'b1;
         gap = (hold_len > 0) ? hold_len : (no_gaps ? 0 : $urandom_range(0, 14));
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            if (hold_len == 0 && $urandom_range(0, 1) == 1) begin
               do @(posedge clock); while (!rsp_valid);
               @(negedge clock);
            end
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] lux, input logic hold);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_lux_q8 <= lux;
      req_hold_updates  <= hold;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings++;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] depth,
                            input logic [CSR_DATA_W-1:0] gate);
      drain();
      write_reg(REG_SAMPLE_COUNT, depth);
      write_reg(REG_MIN_CHANGE, gate);
   endtask

   // bursts that track a level with jitter around the change gate, plus noise and steps
   task automatic run_phase(input int n_items, input logic [CSR_DATA_W-1:0] gate);
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] lux;
      longint              v;
      int                  spread;
      int                  burst;
      int                  done;
      done = 0;
      while (done < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: base = SAMPLE_W'($urandom_range(0, 4000));
            4, 5, 6:    base = SAMPLE_W'($urandom_range(0, 1 << 18));
            7:          base = SAMPLE_W'(LUX_MAX - $urandom_range(0, 1000));
            default:    base = SAMPLE_W'($urandom);
         endcase
         spread = 3 * gate + $urandom_range(1, 8);
         burst = $urandom_range(3, 20);
         while (burst > 0 && done < n_items) begin
            case ($urandom_range(0, 9))
               0: lux = SAMPLE_W'($urandom);
               1: begin
                  base = SAMPLE_W'($urandom_range(0, 1) ? $urandom
                                                         : $urandom_range(0, 600));
                  lux = base;
               end
               default: begin
                  v = longint'(base) + $urandom_range(0, 2 * spread) - spread;
                  if (v < 0) v = 0;
                  if (v > longint'(LUX_MAX)) v = longint'(LUX_MAX);
                  lux = SAMPLE_W'(v);
               end
            endcase
            send_sample(lux, $urandom_range(0, 5) == 0);
            done++;
            burst--;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pass-through at reset settings: gate edges, hold, bit patterns
      send_sample(25'd0, 1'b0);
      send_sample(LUX_MAX, 1'b0);
      send_sample(LUX_MAX, 1'b0);
      send_sample(25'h0000100, 1'b1);
      send_sample(25'd1, 1'b0);
      send_sample(25'h0000100, 1'b0);
      send_sample(25'h000014A, 1'b0);
      send_sample(25'h0000152, 1'b0);
      send_sample(25'h1555555, 1'b0);
      send_sample(25'h0AAAAAA, 1'b0);
      // depth clamps to the maximum, full-scale input, zero gate
      configure(8'hFF, 8'd0);
      repeat (4) send_sample(LUX_MAX, 1'b0);
      send_sample(LUX_MAX, 1'b1);
      repeat (2) send_sample(25'd0, 1'b0);
      // depth zero clamps to pass-through, widest gate
      configure(8'h10, 8'd255);
      send_sample(25'd200, 1'b0);
      send_sample(25'd30000, 1'b0);
      send_sample(25'd30100, 1'b0);

      configure(8'h02, CSR_DATA_W'($urandom_range(0, 255)));
      run_phase(104, 8'd64);
      configure(8'h0A, 8'd0);
      no_gaps = 1'b1;
      run_phase(104, 8'd0);
      no_gaps = 1'b0;
      configure(8'hF3, 8'd255);
      long_hold_cycles = 250;
      run_phase(104, 8'd255);
      configure(8'h00, 8'd1);
      run_phase(52, 8'd1);
      drain();
      write_reg(REG_MIN_CHANGE, 8'd40);
      run_phase(52, 8'd40);
      configure(8'h0B, 8'd20);
      run_phase(104, 8'd20);
      configure(CSR_DATA_W'($urandom_range(0, 255)), 8'd128);
      run_phase(104, 8'd128);
      configure(8'h01, CSR_DATA_W'($urandom_range(0, 255)));
      run_phase(104, 8'd32);
      configure(CSR_DATA_W'($urandom_range(0, 255)), 8'd8);
      run_phase(104, 8'd8);

      drain();
      repeat (40) @(posedge clock);
      $display("covered %0d transactions, %0d of them with a new value reported",
               checked, updates);
      $display("ran %0d register writes over depths 1 to 10, gates 0 to 255, with stalls",
               settings);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/lsg_pkg.sv
hw/rtl/lsg_divider.sv
hw/rtl/lux_smoother_with_change_gate.sv
dv/lux_gate_checker.sv
dv/tb_lux_smoother_with_change_gate.sv
